// ===== hdl/tuit_pkg.sv =====
// Shared types and constants for the timing-unit instruction tracker.
package tuit_pkg;

  // Timing-unit opcodes; codes 6 and 7 carry no meaning and only bump the counter.
  typedef enum logic [2:0] {
    OP_SLEEP   = 3'd0,
    OP_AT      = 3'd1,
    OP_OFFSET  = 3'd2,
    OP_SYNCHRO = 3'd3,
    OP_MOVE    = 3'd4,
    OP_WAIT    = 3'd5
  } op_t;

  // Register indexes in the cache with a side effect or a read-back.
  localparam logic [4:0] REG_SERIAL = 5'd0;
  localparam logic [4:0] REG_ACCESS = 5'd1;
  localparam logic [4:0] REG_DATA_B1 = 5'd2;
  localparam logic [4:0] REG_DATA_B2 = 5'd3;
  localparam logic [4:0] REG_DATA_B3 = 5'd4;
  localparam logic [4:0] REG_DATA_B0 = 5'd5;
  localparam logic [4:0] REG_ACT_LO = 5'd6;
  localparam logic [4:0] REG_ACT_HI = 5'd7;

  // Tracker state. Only the cached bytes that feed serial data are kept.
  typedef struct packed {
    logic [15:0] qbit;
    logic [7:0]  data_b1;
    logic [7:0]  data_b2;
    logic [7:0]  data_b3;
    logic [7:0]  data_b0;
    logic [15:0] activity;
  } track_state_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] qbit_count;
    logic [2:0]  opcode;
    logic [12:0] param_value;
    logic [4:0]  reg_index;
    logic [7:0]  reg_value;
    logic        serial_valid;
    logic [2:0]  device_index;
    logic [5:0]  bit_length;
    logic [31:0] serial_data;
    logic [1:0]  access_flags;
    logic [15:0] activity_changed;
    logic [15:0] activity_lines;
  } result_t;

endpackage

// ===== hdl/tuit_if.sv =====
// Handshake interfaces for instruction words and tracker results.
interface tuit_instr_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface tuit_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] qbit_count;
  logic [2:0]  opcode;
  logic [12:0] param_value;
  logic [4:0]  reg_index;
  logic [7:0]  reg_value;
  logic        serial_valid;
  logic [2:0]  device_index;
  logic [5:0]  bit_length;
  logic [31:0] serial_data;
  logic [1:0]  access_flags;
  logic [15:0] activity_changed;
  logic [15:0] activity_lines;

  modport source (
    output valid, input ready,
    output qbit_count, output opcode, output param_value, output reg_index,
    output reg_value, output serial_valid, output device_index, output bit_length,
    output serial_data, output access_flags, output activity_changed,
    output activity_lines
  );
  modport sink (
    input valid, output ready,
    input qbit_count, input opcode, input param_value, input reg_index,
    input reg_value, input serial_valid, input device_index, input bit_length,
    input serial_data, input access_flags, input activity_changed,
    input activity_lines
  );
endinterface

// ===== hdl/timing_unit_instruction_tracker.sv =====
// Timing-unit instruction tracker top level.
// An accepted instruction beat passes the input register, then the result
// register, on its way to its result beat.
// Throughput: one instruction per cycle unless result.ready stalls; execute
// reads and updates counter, byte cache and activity image combinationally.
// Reset (synchronous, rst high) clears counter, cache, activity image and valids.
module timing_unit_instruction_tracker (
  input  logic          clk,
  input  logic          rst,
  tuit_instr_if.sink    instr,
  tuit_result_if.source result
);
  import tuit_pkg::*;

  logic         in_valid;
  logic [15:0]  in_word;
  logic         out_valid;
  result_t      out_res;
  track_state_t st;
  track_state_t st_next;
  result_t      res_next;
  logic         advance;

  // Move the held word to the result register when that slot frees up.
  assign advance     = in_valid && (!out_valid || result.ready);
  assign instr.ready = !in_valid || advance;

  tuit_exec u_exec (
    .instr_word (in_word),
    .st         (st),
    .st_next    (st_next),
    .res        (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (instr.ready) begin
      in_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      in_word <= instr.instr_word;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.qbit_count       = out_res.qbit_count;
  assign result.opcode           = out_res.opcode;
  assign result.param_value      = out_res.param_value;
  assign result.reg_index        = out_res.reg_index;
  assign result.reg_value        = out_res.reg_value;
  assign result.serial_valid     = out_res.serial_valid;
  assign result.device_index     = out_res.device_index;
  assign result.bit_length       = out_res.bit_length;
  assign result.serial_data      = out_res.serial_data;
  assign result.access_flags     = out_res.access_flags;
  assign result.activity_changed = out_res.activity_changed;
  assign result.activity_lines   = out_res.activity_lines;

endmodule

// ===== hdl/tuit_exec.sv =====
// Instruction execute logic: decodes one word against the current state.
module tuit_exec (
  input  logic [15:0]           instr_word,
  input  tuit_pkg::track_state_t st,
  output tuit_pkg::track_state_t st_next,
  output tuit_pkg::result_t     res
);
  import tuit_pkg::*;

  logic [15:0] cnt_inc;
  logic [12:0] param;
  logic [4:0]  addr;
  logic [7:0]  data;

  assign cnt_inc = st.qbit + 16'd1;
  assign param   = instr_word[12:0];
  assign addr    = param[4:0];
  assign data    = param[12:5];

  always_comb begin
    st_next = st;
    st_next.qbit = cnt_inc;

    res = '0;
    res.qbit_count  = cnt_inc;
    res.opcode      = instr_word[15:13];
    res.param_value = param;

    case (op_t'(instr_word[15:13]))
      OP_SLEEP: st_next.qbit = 16'd0;
      OP_AT:    st_next.qbit = {3'd0, param};
      OP_WAIT:  st_next.qbit = cnt_inc + {3'd0, param};
      OP_MOVE: begin
        res.reg_index = addr;
        res.reg_value = data;
        // cached bytes that feed serial data
        if (addr == REG_DATA_B1) st_next.data_b1 = data;
        if (addr == REG_DATA_B2) st_next.data_b2 = data;
        if (addr == REG_DATA_B3) st_next.data_b3 = data;
        if (addr == REG_DATA_B0) st_next.data_b0 = data;
        // serial start: data width follows the length in whole bytes
        if (addr == REG_SERIAL) begin
          res.serial_valid = 1'b1;
          res.device_index = data[7:5];
          res.bit_length   = {1'b0, data[4:0]} + 6'd1;
          case (data[4:3])
            2'd0:    res.serial_data = {24'd0, st.data_b3};
            2'd1:    res.serial_data = {16'd0, st.data_b3, st.data_b2};
            2'd2:    res.serial_data = {8'd0, st.data_b3, st.data_b2, st.data_b1};
            default: res.serial_data = {st.data_b3, st.data_b2, st.data_b1, st.data_b0};
          endcase
        end
        if (addr == REG_ACCESS) res.access_flags = data[1:0];
        // activity lines, low and high byte
        if (addr == REG_ACT_LO) st_next.activity = {st.activity[15:8], data};
        if (addr == REG_ACT_HI) st_next.activity = {data, st.activity[7:0]};
      end
      default: ;
    endcase

    res.activity_changed = st_next.activity ^ st.activity;
    res.activity_lines   = st_next.activity;
  end

endmodule

// ===== bench/timing_unit_instruction_tracker_test.sv =====
// Self-checking testbench for the timing-unit instruction tracker.
`timescale 1ns / 1ps

module timing_unit_instruction_tracker_test;
  import tuit_pkg::*;

  localparam int RANDOM_ITEMS  = 1100;
  localparam int PHASES        = 4;
  localparam int MAX_GAP       = 18;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_REPORTS   = 40;

  // Tracker predictor and the queue of result beats it expects.
  class tracker_scoreboard;
    bit [15:0] qbit;
    bit [7:0]  cache [32];
    bit [15:0] activity;
    result_t   expected_q [$];
    int        errors;
    int        reports;

    // Work out the result beat for one accepted instruction beat.
    function void note_instr(logic [15:0] word);
      result_t     r;
      logic [2:0]  opc;
      logic [12:0] param;
      logic [4:0]  idx;
      logic [7:0]  dval;
      logic [5:0]  len;
      logic [15:0] nxt;
      r = '0;
      opc = word[15:13];
      param = word[12:0];
      qbit = qbit + 16'd1;
      r.qbit_count = qbit;
      r.opcode = opc;
      r.param_value = param;
      case (opc)
        OP_SLEEP: qbit = '0;
        OP_AT:    qbit = {3'b000, param};
        OP_WAIT:  qbit = qbit + {3'b000, param};
        OP_MOVE: begin
          idx = param[4:0];
          dval = param[12:5];
          r.reg_index = idx;
          r.reg_value = dval;
          cache[idx] = dval;
          if (idx == REG_SERIAL) begin
            len = {1'b0, dval[4:0]} + 6'd1;
            r.serial_valid = 1'b1;
            r.device_index = dval[7:5];
            r.bit_length = len;
            // serial word grows by one cached byte per 8 bits of length
            if (len <= 6'd8)
              r.serial_data = {24'd0, cache[REG_DATA_B3]};
            else if (len <= 6'd16)
              r.serial_data = {16'd0, cache[REG_DATA_B3], cache[REG_DATA_B2]};
            else if (len <= 6'd24)
              r.serial_data = {8'd0, cache[REG_DATA_B3], cache[REG_DATA_B2],
                               cache[REG_DATA_B1]};
            else
              r.serial_data = {cache[REG_DATA_B3], cache[REG_DATA_B2],
                               cache[REG_DATA_B1], cache[REG_DATA_B0]};
          end else if (idx == REG_ACCESS) begin
            r.access_flags = dval[1:0];
          end else if (idx == REG_ACT_LO) begin
            nxt = {activity[15:8], dval};
            r.activity_changed = nxt ^ activity;
            activity = nxt;
          end else if (idx == REG_ACT_HI) begin
            nxt = {dval, activity[7:0]};
            r.activity_changed = nxt ^ activity;
            activity = nxt;
          end
        end
        default: ;
      endcase
      r.activity_lines = activity;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
        end
      end
    endfunction

    // Compare one result beat against the oldest expectation.
    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected result beat: expected none, got %p", $time, got);
        end
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("qbit_count", 32'(exp_r.qbit_count), 32'(got.qbit_count));
      compare_field("opcode", 32'(exp_r.opcode), 32'(got.opcode));
      compare_field("param_value", 32'(exp_r.param_value), 32'(got.param_value));
      compare_field("reg_index", 32'(exp_r.reg_index), 32'(got.reg_index));
      compare_field("reg_value", 32'(exp_r.reg_value), 32'(got.reg_value));
      compare_field("serial_valid", 32'(exp_r.serial_valid), 32'(got.serial_valid));
      compare_field("device_index", 32'(exp_r.device_index), 32'(got.device_index));
      compare_field("bit_length", 32'(exp_r.bit_length), 32'(got.bit_length));
      compare_field("serial_data", exp_r.serial_data, got.serial_data);
      compare_field("access_flags", 32'(exp_r.access_flags), 32'(got.access_flags));
      compare_field("activity_changed", 32'(exp_r.activity_changed),
                    32'(got.activity_changed));
      compare_field("activity_lines", 32'(exp_r.activity_lines),
                    32'(got.activity_lines));
    endfunction
  endclass

  logic clk;
  logic rst;

  tuit_instr_if  instr ();
  tuit_result_if result ();

  timing_unit_instruction_tracker DUT (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr),
    .result (result)
  );

  tracker_scoreboard sb = new;

  bit no_idle;
  int long_hold;
  int stall_cycles;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Beat monitor and stall watchdog
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (instr.valid && instr.ready) sb.note_instr(instr.instr_word);
      if (result.valid && result.ready)
        sb.check_result({result.qbit_count, result.opcode, result.param_value,
                         result.reg_index, result.reg_value, result.serial_valid,
                         result.device_index, result.bit_length, result.serial_data,
                         result.access_flags, result.activity_changed,
                         result.activity_lines});
    end
    if ((instr.valid && instr.ready) || (result.valid && result.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timing_unit_instruction_tracker_test: errors");
      $finish;
    end
  end

  // Result receiver: random holds, plus one long hold on request
  initial begin
    int gap;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold > 0) begin
        gap = long_hold;
        long_hold = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  function automatic logic [15:0] make_word(logic [2:0] opc, logic [12:0] param);
    return {opc, param};
  endfunction

  function automatic logic [15:0] move_word(logic [4:0] idx, logic [7:0] dval);
    return {OP_MOVE, dval, idx};
  endfunction

  // Offer one instruction beat after a random gap and wait for it to be taken.
  task automatic send_word(logic [15:0] word);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      instr.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr.valid <= 1'b1;
    instr.instr_word <= word;
    do @(posedge clk); while (!instr.ready);
  endtask

  // Random mix: raw words, moves into the side-effect registers, counter loads
  function automatic logic [15:0] random_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) return 16'($urandom);
    if (pick <= 8) return move_word(5'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    case ($urandom_range(0, 2))
      0: return make_word(OP_AT, 13'($urandom_range(0, 8191)));
      1: return make_word(OP_WAIT, 13'($urandom_range(0, 8191)));
      default: return make_word(OP_SLEEP, 13'($urandom_range(0, 8191)));
    endcase
  endfunction

  initial begin
    rst <= 1'b1;
    instr.valid <= 1'b0;
    instr.instr_word <= '0;
    no_idle = 1'b0;
    long_hold = 0;
    stall_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: counter extremes and wrap, then every register side effect
    send_word(make_word(OP_SLEEP, 13'h0000));
    send_word(make_word(OP_AT, 13'h1fff));
    repeat (8) send_word(make_word(OP_WAIT, 13'h1fff));
    send_word(move_word(REG_DATA_B1, 8'hff));
    send_word(move_word(REG_DATA_B2, 8'ha5));
    send_word(move_word(REG_DATA_B3, 8'h5a));
    send_word(move_word(REG_DATA_B0, 8'h3c));
    send_word(move_word(REG_SERIAL, 8'h00));
    send_word(move_word(REG_SERIAL, 8'h48));
    send_word(move_word(REG_SERIAL, 8'hb0));
    send_word(move_word(REG_SERIAL, 8'hff));
    send_word(move_word(REG_ACCESS, 8'h03));
    send_word(move_word(REG_ACT_LO, 8'hff));
    send_word(move_word(REG_ACT_HI, 8'hff));
    // same byte again: no lines change
    send_word(move_word(REG_ACT_LO, 8'hff));
    send_word(move_word(REG_ACT_HI, 8'h00));
    send_word(move_word(5'd31, 8'hff));
    send_word(make_word(OP_OFFSET, 13'h1fff));
    send_word(make_word(OP_SYNCHRO, 13'h1fff));
    send_word(make_word(3'd6, 13'h1fff));
    send_word(make_word(3'd7, 13'h1fff));

    // Random phases: normal, back to back, long receiver hold, normal
    for (int ph = 0; ph < PHASES; ph++) begin
      no_idle = (ph == 1);
      if (ph == 2) long_hold = LONG_HOLD;
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) send_word(random_word());
    end
    instr.valid <= 1'b0;

    // Drain, then wait DRAIN_CYCLES so the pipeline can show any extra beat
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("timing_unit_instruction_tracker_test: clean");
    else
      $display("timing_unit_instruction_tracker_test: errors");
    $finish;
  end

endmodule
